@@ hw/rtl/niq_pkg.sv @@
// niq_pkg: widths, codes and item types shared by the interpolator modules
// no dependencies
`timescale 1ns / 1ps

package niq_pkg;

  localparam int FracBits  = 16;
  localparam int InW       = 32;
  localparam int MagW      = InW + 1;
  localparam int BigW      = 63;
  localparam int DivW      = BigW + FracBits;
  localparam int TW        = BigW - FracBits;
  localparam int SumW      = TW + 2;
  localparam int ProdW     = BigW + MagW;
  localparam int MulSplit  = 32;
  localparam int MulLat    = 3;
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  localparam logic [BigW-1:0] SatBound = {1'b1, {(BigW-1){1'b0}}};

  typedef enum logic [1:0] {
    OrdConst  = 2'd0,
    OrdLinear = 2'd1,
    OrdQuad   = 2'd2,
    OrdBad    = 2'd3
  } order_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StOrder    = 2'd1,
    StCoincide = 2'd2,
    StSat      = 2'd3
  } status_e;

  typedef struct packed {
    logic            sgn;
    logic [MagW-1:0] mag;
  } sm_t;

  typedef struct packed {
    order_e                 ord;
    status_e                pre;
    logic signed [InW-1:0]  y0;
    sm_t                    n01;
    sm_t                    d01;
    sm_t                    n12;
    sm_t                    d12;
    sm_t                    d02;
    sm_t                    dq0;
    sm_t                    dq1;
  } entry_t;

  typedef struct packed {
    logic                   valid;
    order_e                 ord;
    status_e                pre;
    logic signed [InW-1:0]  y0;
    logic [MagW-1:0]        dq0_mag;
    logic                   dq0_sgn;
    logic [MagW-1:0]        dq1_mag;
    logic                   dq1_sgn;
    logic [MagW-1:0]        d02_mag;
    logic                   d02_sgn;
    logic                   f12_sgn;
    logic [BigW-1:0]        f01_mag;
    logic                   f01_sgn;
    logic                   c2_sgn;
    logic                   sat1;
    logic                   sat2;
    logic [TW-1:0]          t1_mag;
    logic                   t1_sgn;
  } lane_t;

endpackage

@@ hw/rtl/niq_front.sv @@
// niq_front: classifies an incoming sample set and forms exact differences
// depends on niq_pkg
`timescale 1ns / 1ps

module niq_front (
  input  logic [1:0]                      order_i,
  input  logic signed [niq_pkg::InW-1:0]  point_x0_i,
  input  logic signed [niq_pkg::InW-1:0]  point_x1_i,
  input  logic signed [niq_pkg::InW-1:0]  point_x2_i,
  input  logic signed [niq_pkg::InW-1:0]  point_y0_i,
  input  logic signed [niq_pkg::InW-1:0]  point_y1_i,
  input  logic signed [niq_pkg::InW-1:0]  point_y2_i,
  input  logic signed [niq_pkg::InW-1:0]  query_x_i,
  output niq_pkg::entry_t                 entry_o
);
  import niq_pkg::*;

  function automatic sm_t sm_diff(input logic signed [InW-1:0] a,
                                  input logic signed [InW-1:0] b);
    logic signed [MagW-1:0] d;
    logic [MagW-1:0]        u;
    sm_t                    r;
    d     = MagW'(a) - MagW'(b);
    u     = d;
    r.sgn = u[MagW-1];
    r.mag = r.sgn ? (~u + 1'b1) : u;
    return r;
  endfunction

  order_e ord;
  logic   same01, same12, same02;

  assign ord    = order_e'(order_i);
  assign same01 = (point_x1_i == point_x0_i);
  assign same12 = (point_x2_i == point_x1_i);
  assign same02 = (point_x2_i == point_x0_i);

  always_comb begin
    entry_o.ord = ord;
    if (ord == OrdBad) begin
      entry_o.pre = StOrder;
    end else if ((ord != OrdConst && same01) || (ord == OrdQuad && (same12 || same02))) begin
      entry_o.pre = StCoincide;
    end else begin
      entry_o.pre = StOk;
    end
    entry_o.y0  = point_y0_i;
    entry_o.n01 = sm_diff(point_y1_i, point_y0_i);
    entry_o.d01 = sm_diff(point_x1_i, point_x0_i);
    entry_o.n12 = sm_diff(point_y2_i, point_y1_i);
    entry_o.d12 = sm_diff(point_x2_i, point_x1_i);
    entry_o.d02 = sm_diff(point_x2_i, point_x0_i);
    entry_o.dq0 = sm_diff(query_x_i, point_x0_i);
    entry_o.dq1 = sm_diff(query_x_i, point_x1_i);
  end

endmodule

@@ hw/rtl/niq_fifo.sv @@
// niq_fifo: short queue of classified items between front and back
// depends on niq_pkg
`timescale 1ns / 1ps

module niq_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  niq_pkg::entry_t  entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output niq_pkg::entry_t  entry_o
);
  import niq_pkg::*;

  entry_t              mem_q [FifoDepth];
  logic [FifoAw-1:0]   wr_q, rd_q;
  logic [FifoAw:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/niq_div.sv @@
// niq_div: pipelined restoring divider, one quotient bit per stage
// depends on niq_pkg
`timescale 1ns / 1ps

module niq_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [niq_pkg::DivW-1:0]   dividend_i,
  input  logic [niq_pkg::MagW-1:0]   divisor_i,
  output logic [niq_pkg::DivW-1:0]   quotient_o
);
  import niq_pkg::*;

  logic [DivW-1:0] w_q  [DivW];
  logic [MagW-1:0] r_q  [DivW];
  logic [MagW-1:0] dv_q [DivW];

  for (genvar k = 0; k < DivW; k++) begin : g_stage
    logic [DivW-1:0] w_in;
    logic [MagW-1:0] r_in, dv_in;
    logic [MagW:0]   trial, diff;
    logic            fits;

    if (k == 0) begin : g_first
      assign w_in  = dividend_i;
      assign r_in  = '0;
      assign dv_in = divisor_i;
    end else begin : g_next
      assign w_in  = w_q[k-1];
      assign r_in  = r_q[k-1];
      assign dv_in = dv_q[k-1];
    end

    assign trial = {r_in, w_in[DivW-1]};
    assign diff  = trial - {1'b0, dv_in};
    assign fits  = (trial >= {1'b0, dv_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        w_q[k]  <= {w_in[DivW-2:0], fits};
        r_q[k]  <= fits ? diff[MagW-1:0] : trial[MagW-1:0];
        dv_q[k] <= dv_in;
      end
    end
  end

  assign quotient_o = w_q[DivW-1];

endmodule

@@ hw/rtl/niq_mul.sv @@
// niq_mul: split magnitude multiplier with clamp and fixed-point rescale
// depends on niq_pkg
`timescale 1ns / 1ps

module niq_mul (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [niq_pkg::BigW-1:0]   a_i,
  input  logic [niq_pkg::MagW-1:0]   b_i,
  output logic [niq_pkg::TW-1:0]     mag_o,
  output logic                       sat_o
);
  import niq_pkg::*;

  logic [MulSplit+MagW-1:0]      lo_q;
  logic [BigW-MulSplit+MagW-1:0] hi_q;
  logic [ProdW-1:0]              p_q;
  logic [TW-1:0]                 mag_q;
  logic                          sat_q;
  logic                          sat_d;
  logic [BigW-1:0]               clip_d;

  assign sat_d  = (p_q > {{(ProdW-BigW){1'b0}}, SatBound});
  assign clip_d = sat_d ? SatBound : p_q[BigW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q  <= a_i[MulSplit-1:0] * b_i;
      hi_q  <= a_i[BigW-1:MulSplit] * b_i;
      p_q   <= {hi_q, {MulSplit{1'b0}}} + {{(ProdW-MulSplit-MagW){1'b0}}, lo_q};
      mag_q <= clip_d[BigW-1:FracBits];
      sat_q <= sat_d;
    end
  end

  assign mag_o = mag_q;
  assign sat_o = sat_q;

endmodule

@@ hw/rtl/niq_back.sv @@
// niq_back: divided differences, Newton products, final sum and output register
// depends on niq_pkg, niq_div, niq_mul
`timescale 1ns / 1ps

module niq_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  niq_pkg::entry_t            head_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [niq_pkg::InW-1:0] value_o,
  output logic [1:0]                 status_o
);
  import niq_pkg::*;

  localparam int SW = BigW + 2;
  localparam logic signed [SW-1:0]   DPos   = {2'b00, SatBound};
  localparam logic signed [SW-1:0]   DNeg   = -DPos;
  localparam logic signed [SumW-1:0] OutMax = SumW'(2147483647);
  localparam logic signed [SumW-1:0] OutMin = -OutMax - SumW'(1);

  logic en;

  entry_t s0_q;
  logic   s0_vld_q;
  lane_t  lane0;
  lane_t  sb1_q [DivW];
  lane_t  sd_q;
  logic [BigW-1:0] sd_dmag_q;
  lane_t  sb2_q [DivW];
  lane_t  se_q;
  logic [BigW-1:0] se_c2mag_q;
  lane_t  sb3_q [MulLat];
  lane_t  lane4;
  lane_t  sb4_q [MulLat];

  logic      out_valid_q;
  logic signed [InW-1:0] value_q;
  status_e   status_q;

  logic [DivW-1:0] q01, q12, qc2;
  logic [TW-1:0]   a_mag, b_mag, c_mag;
  logic            a_sat, b_sat, c_sat;

  lane_t                 sd_d;
  logic signed [SW-1:0]  f01_s, f12_s, dd, dcl;
  logic [SW-1:0]         dabs;

  lane_t se_d;
  logic  c2_sat;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= head_i;
    end
  end

  always_comb begin
    lane0         = '0;
    lane0.valid   = s0_vld_q;
    lane0.ord     = s0_q.ord;
    lane0.pre     = s0_q.pre;
    lane0.y0      = s0_q.y0;
    lane0.dq0_mag = s0_q.dq0.mag;
    lane0.dq0_sgn = s0_q.dq0.sgn;
    lane0.dq1_mag = s0_q.dq1.mag;
    lane0.dq1_sgn = s0_q.dq1.sgn;
    lane0.d02_mag = s0_q.d02.mag;
    lane0.d02_sgn = s0_q.d02.sgn;
    lane0.f01_sgn = s0_q.n01.sgn ^ s0_q.d01.sgn;
    lane0.f12_sgn = s0_q.n12.sgn ^ s0_q.d12.sgn;
  end

  // first differences
  niq_div u_div01 (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({{(DivW-MagW-FracBits){1'b0}}, s0_q.n01.mag, {FracBits{1'b0}}}),
    .divisor_i  (s0_q.d01.mag),
    .quotient_o (q01)
  );

  niq_div u_div12 (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({{(DivW-MagW-FracBits){1'b0}}, s0_q.n12.mag, {FracBits{1'b0}}}),
    .divisor_i  (s0_q.d12.mag),
    .quotient_o (q12)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivW; k++) begin
        sb1_q[k] <= '0;
        sb2_q[k] <= '0;
      end
      for (int k = 0; k < MulLat; k++) begin
        sb3_q[k] <= '0;
        sb4_q[k] <= '0;
      end
      sd_q <= '0;
      se_q <= '0;
    end else if (en) begin
      sb1_q[0] <= lane0;
      sb2_q[0] <= sd_q;
      sb3_q[0] <= se_q;
      sb4_q[0] <= lane4;
      for (int k = 1; k < DivW; k++) begin
        sb1_q[k] <= sb1_q[k-1];
        sb2_q[k] <= sb2_q[k-1];
      end
      for (int k = 1; k < MulLat; k++) begin
        sb3_q[k] <= sb3_q[k-1];
        sb4_q[k] <= sb4_q[k-1];
      end
      sd_q <= sd_d;
      se_q <= se_d;
    end
  end

  // f12 - f01, clamped
  always_comb begin
    f01_s   = {2'b00, q01[BigW-1:0]};
    f12_s   = {2'b00, q12[BigW-1:0]};
    if (sb1_q[DivW-1].f01_sgn) f01_s = -f01_s;
    if (sb1_q[DivW-1].f12_sgn) f12_s = -f12_s;
    dd      = f12_s - f01_s;
    if (dd > DPos) begin
      dcl = DPos;
    end else if (dd < DNeg) begin
      dcl = DNeg;
    end else begin
      dcl = dd;
    end
    dabs         = dcl[SW-1] ? -dcl : dcl;
    sd_d         = sb1_q[DivW-1];
    sd_d.f01_mag = q01[BigW-1:0];
    sd_d.c2_sgn  = dcl[SW-1] ^ sb1_q[DivW-1].d02_sgn;
    sd_d.sat2    = (dd > DPos) || (dd < DNeg);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_dmag_q <= dabs[BigW-1:0];
    end
  end

  // second difference
  niq_div u_div02 (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({sd_dmag_q, {FracBits{1'b0}}}),
    .divisor_i  (sd_q.d02_mag),
    .quotient_o (qc2)
  );

  assign c2_sat = (qc2 > {{(DivW-BigW){1'b0}}, SatBound});

  always_comb begin
    se_d      = sb2_q[DivW-1];
    se_d.sat2 = sb2_q[DivW-1].sat2 | c2_sat;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      se_c2mag_q <= c2_sat ? SatBound : qc2[BigW-1:0];
    end
  end

  // c2*(q-x0) and f01*(q-x0)
  niq_mul u_mul_a (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (se_c2mag_q),
    .b_i   (se_q.dq0_mag),
    .mag_o (a_mag),
    .sat_o (a_sat)
  );

  niq_mul u_mul_b (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (se_q.f01_mag),
    .b_i   (se_q.dq0_mag),
    .mag_o (b_mag),
    .sat_o (b_sat)
  );

  always_comb begin
    lane4        = sb3_q[MulLat-1];
    lane4.t1_mag = b_mag;
    lane4.t1_sgn = sb3_q[MulLat-1].f01_sgn ^ sb3_q[MulLat-1].dq0_sgn;
    lane4.sat1   = b_sat;
    lane4.sat2   = sb3_q[MulLat-1].sat2 | a_sat;
    lane4.c2_sgn = sb3_q[MulLat-1].c2_sgn ^ sb3_q[MulLat-1].dq0_sgn;
  end

  // times (q-x1)
  niq_mul u_mul_c (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   ({{(BigW-TW){1'b0}}, a_mag}),
    .b_i   (sb3_q[MulLat-1].dq1_mag),
    .mag_o (c_mag),
    .sat_o (c_sat)
  );

  lane_t                  fin;
  logic                   quad;
  logic signed [SumW-1:0] t1_s, t2_s, y0_s, sum;
  logic                   sat_all;
  logic signed [InW-1:0]  value_d;
  status_e                status_d;

  always_comb begin
    fin  = sb4_q[MulLat-1];
    quad = (fin.ord == OrdQuad);
    y0_s = SumW'(fin.y0);
    t1_s = {2'b00, fin.t1_mag};
    if (fin.t1_sgn) t1_s = -t1_s;
    t2_s = '0;
    if (quad) begin
      t2_s = {2'b00, c_mag};
      if (fin.c2_sgn ^ fin.dq1_sgn) t2_s = -t2_s;
    end
    sum     = y0_s + t1_s + t2_s;
    sat_all = fin.sat1 || (quad && (fin.sat2 || c_sat)) || (sum > OutMax) || (sum < OutMin);
    if (fin.pre != StOk) begin
      value_d  = '0;
      status_d = fin.pre;
    end else if (fin.ord == OrdConst) begin
      value_d  = fin.y0;
      status_d = StOk;
    end else begin
      if (sum > OutMax) begin
        value_d = OutMax[InW-1:0];
      end else if (sum < OutMin) begin
        value_d = OutMin[InW-1:0];
      end else begin
        value_d = sum[InW-1:0];
      end
      status_d = sat_all ? StSat : StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(value_q) && $stable(status_q))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == StOrder || status_q == StCoincide) |-> value_q == '0)
    else $error("error result carries nonzero value");

  a_no_pop_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !pop_o)
    else $error("queue popped while back end stalled");

endmodule

@@ hw/rtl/newton_interpolation_upto_quadratic.sv @@
// newton_interpolation_upto_quadratic: Newton divided-difference interpolation, order 0..2
// depends on niq_pkg, niq_front, niq_fifo, niq_back
//
// Input channel (in_valid_i/in_ready_o) carries an order and three sample
// points and a query abscissa, all Q16.16. One transfer gives exactly one result on
// the output channel (out_valid_o/out_ready_i): the interpolated value and a
// status (ok, unsupported order, coincident abscissae, saturated).
// From input transfer to out_valid_o each item passes through two pipelined
// dividers in series (one quotient bit per stage) and then through the two
// Q16.16 rescaling multipliers in series after them.
// Throughput is one item per cycle while the receiver takes results.
// The front classifies and forms differences into a four-entry queue; the back
// pipeline advances as one unit whenever the output register is empty or taken.
// When the receiver stalls the back pipeline holds, the queue fills, and
// in_ready_o falls once it is full. Reset empties the queue and clears all
// valid flags; no result is pending afterwards.
`timescale 1ns / 1ps

module newton_interpolation_upto_quadratic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     order_i,
  input  logic signed [niq_pkg::InW-1:0] point_x0_i,
  input  logic signed [niq_pkg::InW-1:0] point_x1_i,
  input  logic signed [niq_pkg::InW-1:0] point_x2_i,
  input  logic signed [niq_pkg::InW-1:0] point_y0_i,
  input  logic signed [niq_pkg::InW-1:0] point_y1_i,
  input  logic signed [niq_pkg::InW-1:0] point_y2_i,
  input  logic signed [niq_pkg::InW-1:0] query_x_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [niq_pkg::InW-1:0] value_o,
  output logic [1:0]                     status_o
);
  import niq_pkg::*;

  entry_t front_entry, head;
  logic   full, empty, pop;

  niq_front u_front (
    .order_i    (order_i),
    .point_x0_i (point_x0_i),
    .point_x1_i (point_x1_i),
    .point_x2_i (point_x2_i),
    .point_y0_i (point_y0_i),
    .point_y1_i (point_y1_i),
    .point_y2_i (point_y2_i),
    .query_x_i  (query_x_i),
    .entry_o    (front_entry)
  );

  niq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (head)
  );

  assign in_ready_o = !full;

  niq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

endmodule

@@ bench/testbench.sv @@
// testbench for newton_interpolation_upto_quadratic: directed table then random sample sets
// depends on niq_pkg and the interpolator rtl; results checked against a built-in predictor
`timescale 1ns / 1ps

module testbench;
  import niq_pkg::*;

  typedef struct {
    order_e           ord;
    logic signed [31:0] x0, x1, x2, y0, y1, y2, qx;
    bit               typed;
    logic signed [31:0] val;
    status_e          st;
  } sample_set_t;

  typedef struct {
    logic signed [31:0] val;
    status_e          st;
  } interp_t;

  localparam longint Bound62  = 64'sd1 <<< 62;
  localparam longint OneQ     = 64'sd1 <<< FracBits;
  localparam int     Latency  = 2 * (63 + FracBits) + 10;
  localparam int     IdleLimit = 20 * Latency;
  localparam int     NumRandom = 1200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] order_i = OrdConst;
  logic signed [31:0] point_x0_i = '0, point_x1_i = '0, point_x2_i = '0;
  logic signed [31:0] point_y0_i = '0, point_y1_i = '0, point_y2_i = '0;
  logic signed [31:0] query_x_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] value_o;
  logic [1:0] status_o;

  interp_t expected_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit burst_mode = 1'b0;

  newton_interpolation_upto_quadratic dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp62(longint v, inout bit sat);
    if (v > Bound62) begin
      sat = 1'b1;
      return Bound62;
    end
    if (v < -Bound62) begin
      sat = 1'b1;
      return -Bound62;
    end
    return v;
  endfunction

  function automatic longint mag_mul(longint a, longint b, inout bit sat);
    longint unsigned ua, ub, m;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    if (ua != 0 && ub > longint'(Bound62) / ua) begin
      sat = 1'b1;
      m = Bound62;
    end else begin
      m = ua * ub;
    end
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fx_mul(longint a, longint b, inout bit sat);
    return mag_mul(a, b, sat) / OneQ;
  endfunction

  function automatic longint fx_div(longint num, longint den, inout bit sat);
    longint q, r, hi, lo;
    q = num / den;
    r = num % den;
    hi = mag_mul(q, OneQ, sat);
    lo = (r * OneQ) / den;
    return clamp62(hi + lo, sat);
  endfunction

  function automatic interp_t newton_eval(sample_set_t s);
    interp_t r;
    longint x0, x1, x2, y0, y1, y2, qx, dq0, dq1, f01, f12, c2, acc;
    bit sat;
    x0 = s.x0; x1 = s.x1; x2 = s.x2;
    y0 = s.y0; y1 = s.y1; y2 = s.y2; qx = s.qx;
    sat = 1'b0;
    r.val = '0;
    r.st = StOk;
    if (s.ord == OrdBad) begin
      r.st = StOrder;
    end else if ((s.ord != OrdConst && x1 == x0) ||
                 (s.ord == OrdQuad && (x2 == x1 || x2 == x0))) begin
      r.st = StCoincide;
    end else if (s.ord == OrdConst) begin
      r.val = s.y0;
    end else begin
      dq0 = qx - x0;
      f01 = fx_div(y1 - y0, x1 - x0, sat);
      acc = y0 + fx_mul(f01, dq0, sat);
      if (s.ord == OrdQuad) begin
        dq1 = qx - x1;
        f12 = fx_div(y2 - y1, x2 - x1, sat);
        c2 = fx_div(clamp62(f12 - f01, sat), x2 - x0, sat);
        acc += fx_mul(fx_mul(c2, dq0, sat), dq1, sat);
      end
      if (acc > 64'sd2147483647) begin
        acc = 64'sd2147483647;
        sat = 1'b1;
      end
      if (acc < -64'sd2147483648) begin
        acc = -64'sd2147483648;
        sat = 1'b1;
      end
      r.val = acc[31:0];
      if (sat) r.st = StSat;
    end
    return r;
  endfunction

  function automatic sample_set_t mk(order_e o, int x0, int x1, int x2, int y0,
                                     int y1, int y2, int qx, bit typed = 0,
                                     int val = 0, status_e st = StOk);
    sample_set_t s;
    s.ord = o; s.x0 = x0; s.x1 = x1; s.x2 = x2;
    s.y0 = y0; s.y1 = y1; s.y2 = y2; s.qx = qx;
    s.typed = typed; s.val = val; s.st = st;
    return s;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return int'($urandom_range(0, 1 << 22)) - (1 << 21);
      2: return int'($urandom_range(0, 200 << 16)) - (100 << 16);
      3: case ($urandom_range(0, 4))
           0: return 32'sh7fffffff;
           1: return 32'sh80000000;
           2: return 0;
           3: return 1;
           default: return -1;
         endcase
      default: return int'($urandom_range(0, 20 << 16)) - (10 << 16);
    endcase
  endfunction

  function automatic sample_set_t rand_set();
    sample_set_t s;
    int pick;
    pick = $urandom_range(0, 19);
    s.ord = (pick == 0) ? OrdBad : order_e'($urandom_range(0, 2));
    s.x0 = rand_coord(); s.x1 = rand_coord(); s.x2 = rand_coord();
    s.y0 = rand_coord(); s.y1 = rand_coord(); s.y2 = rand_coord();
    s.qx = rand_coord();
    case ($urandom_range(0, 15))
      0: s.x1 = s.x0;
      1: s.x2 = s.x0;
      2: s.x2 = s.x1;
      default: ;
    endcase
    s.typed = 1'b0;
    return s;
  endfunction

  task automatic send(sample_set_t s);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    order_i <= s.ord;
    point_x0_i <= s.x0; point_x1_i <= s.x1; point_x2_i <= s.x2;
    point_y0_i <= s.y0; point_y1_i <= s.y1; point_y2_i <= s.y2;
    query_x_i <= s.qx;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    if (s.typed) expected_q.push_back('{s.val, s.st});
    else expected_q.push_back(newton_eval(s));
    @(posedge clk_i);
  endtask

  // result side: random stall before each result, bursts with none
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      forever begin
        @(negedge clk_i);
        if (out_valid_o) break;
      end
      @(posedge clk_i);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%0d status=%0d",
                                       value_o, status_o);
      end else begin
        interp_t e;
        e = expected_q.pop_front();
        if (value_o !== e.val || status_o !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                     e.val, e.st, value_o, status_o);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    sample_set_t directed[$];
    directed = '{
      mk(OrdBad, 1, 2, 3, 4, 5, 6, 7, 1, 0, StOrder),
      mk(OrdBad, -1, -1, -1, -1, -1, -1, -1, 1, 0, StOrder),
      mk(OrdLinear, 5 << 16, 5 << 16, 0, 1, 2, 3, 4, 1, 0, StCoincide),
      mk(OrdQuad, 0, 1 << 16, 1 << 16, 1, 2, 3, 4, 1, 0, StCoincide),
      mk(OrdQuad, 3 << 16, 1 << 16, 3 << 16, 1, 2, 3, 4, 1, 0, StCoincide),
      mk(OrdQuad, 7, 7, 7, 1, 2, 3, 4, 1, 0, StCoincide),
      mk(OrdConst, 9, 9, 9, 32'sh7fffffff, 1, 2, 3, 1, 32'sh7fffffff, StOk),
      mk(OrdConst, -1, 0, 1, 32'sh80000000, 5, 5, -1, 1, 32'sh80000000, StOk),
      mk(OrdConst, 0, 0, 0, 0, 0, 0, 0, 1, 0, StOk),
      mk(OrdLinear, 0, 2 << 16, 0, 1 << 16, 5 << 16, 0, 1 << 16),
      mk(OrdLinear, 1 << 16, -(3 << 16), 9, -(2 << 16), 7 << 16, -5, 5 << 16),
      mk(OrdQuad, 0, 1 << 16, 2 << 16, 0, 1 << 16, 4 << 16, 3 << 16),
      mk(OrdQuad, -(1 << 16), 0, 1 << 16, 3 << 16, -(2 << 16), 5 << 16, 1 << 15),
      mk(OrdLinear, 0, 1, 0, 32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff),
      mk(OrdLinear, 32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff, 32'sh80000000,
         0, 32'sh80000000),
      mk(OrdQuad, 0, 1, 2, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
         32'sh7fffffff),
      mk(OrdQuad, 32'sh80000000, 0, 32'sh7fffffff, -1, 32'sh7fffffff, -1, 0),
      mk(OrdQuad, 32'sh7fffffff, 32'sh80000000, -1, 32'sh80000000, 32'sh80000000,
         32'sh7fffffff, 32'sh80000000),
      mk(OrdLinear, 3, 4, 32'sh7fffffff, 10, 11, 32'sh80000000, 3)
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send(directed[i]);
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send(rand_set());
    end
    in_valid_i <= 1'b0;
    burst_mode = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
